// ----- rtl/maot_pkg.sv -----
// Package for the moving-average overvoltage trip block.
// Holds field widths, mode codes, register indexes and reset values.
// No dependencies.
package maot_pkg;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned TOTAL_W  = 14;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_AVERAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_END    = 1'b1;

  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 1'b1;

  localparam logic [MODE_W-1:0] MODE_STABLE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFFLOADING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFF        = 2'd2;

  localparam int unsigned SAMPLE_MAX = 1023;
  localparam logic [SAMPLE_W-1:0] MAX_AVERAGE_RST = 10'd320;
  localparam logic [DUTY_W-1:0]   RAMP_END_RST    = 7'd100;

endpackage

// ----- rtl/maot_if.sv -----
// Valid/ready channel interfaces for the moving-average overvoltage trip block.
// Depends on maot_pkg.
interface maot_in_if
  import maot_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface maot_out_if
  import maot_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [DUTY_W-1:0]  duty;
  logic [TOTAL_W-1:0] window_total;
  logic               window_full;
  logic               tripped_now;
  logic               pwm_running;
  logic               scr_fired;

  modport source (output valid, output mode, output duty, output window_total,
                  output window_full, output tripped_now, output pwm_running,
                  output scr_fired, input ready);
  modport sink   (input valid, input mode, input duty, input window_total,
                  input window_full, input tripped_now, input pwm_running,
                  input scr_fired, output ready);
endinterface

// ----- rtl/moving_average_overvoltage_trip_top.sv -----
// Top level of the moving-average overvoltage trip block.
// Depends on maot_pkg and the channel interfaces in maot_if.sv.
//
// Usage:
//   in_i carries one transaction per ADC sample (opcode 0) or ramp tick
//   (opcode 1). out_o returns exactly one result transaction for each input
//   transaction, in order. Registers max_average (index 0) and ramp_end
//   (index 1) are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
//   The result is registered: a transaction accepted at one edge shows its result
//   on out_o after that edge. Throughput is one transaction per cycle while out_o
//   is not stalled; the window sum update (one subtract, one add, one compare)
//   and the registered ring read of the oldest sample, fetched ahead, set that rate.
//   The result register sits between the channels: in_i.ready stays high
//   while the held result is taken in the same cycle, and drops only while
//   out_o is stalled with a result pending.
//   Reset clears the window, the fill count, the mode (stable) and the duty,
//   and loads max_average = 320 and ramp_end = 100. The sample ring itself is
//   not cleared; entries are read only after being written.
module moving_average_overvoltage_trip_top
  import maot_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  maot_in_if.sink               in_i,
  maot_out_if.source            out_o
);

  localparam int unsigned POS_W  = $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned TOT_W  = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);

  logic [SAMPLE_W-1:0] ring_q [WINDOW_LEN];
  logic [SAMPLE_W-1:0] oldest_q;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [TOT_W-1:0]  thresh_q;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic [DUTY_W-1:0] ramp_end_q;
  logic              tripped_d;

  logic              in_fire;
  logic              smp_en;
  logic              full_q;
  logic              full_d;
  logic [DUTY_W-1:0] duty_inc;

  logic               out_valid_q;
  logic [MODE_W-1:0]  out_mode_q;
  logic [DUTY_W-1:0]  out_duty_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_full_q;
  logic               out_trip_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign smp_en     = in_fire && (in_i.opcode == OP_SAMPLE) && (mode_q == MODE_STABLE);
  assign full_q     = (fill_q == FILL_W'(WINDOW_LEN));
  assign duty_inc   = duty_q + DUTY_W'(1);

  always_comb begin
    pos_d     = pos_q;
    fill_d    = fill_q;
    total_d   = total_q;
    mode_d    = mode_q;
    duty_d    = duty_q;
    tripped_d = 1'b0;
    if (smp_en) begin
      pos_d   = (pos_q == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_q + POS_W'(1);
      fill_d  = full_q ? fill_q : fill_q + FILL_W'(1);
      total_d = total_q - (full_q ? TOT_W'(oldest_q) : '0) + TOT_W'(in_i.sample);
      if ((fill_d == FILL_W'(WINDOW_LEN)) && (total_d > thresh_q)) begin
        mode_d    = MODE_OFFLOADING;
        duty_d    = '0;
        tripped_d = 1'b1;
      end
    end else if (in_fire && (in_i.opcode == OP_TICK) && (mode_q == MODE_OFFLOADING)) begin
      duty_d = duty_inc;
      if (duty_inc >= ramp_end_q) begin
        mode_d = MODE_OFF;
      end
    end
  end

  assign full_d = (fill_d == FILL_W'(WINDOW_LEN));

  // ring memory; the read is registered ahead, at the next write position
  always_ff @(posedge clk_i) begin
    if (smp_en) begin
      ring_q[pos_q] <= in_i.sample;
    end
    oldest_q <= ring_q[pos_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      fill_q     <= '0;
      total_q    <= '0;
      mode_q     <= MODE_STABLE;
      duty_q     <= '0;
      thresh_q   <= TOT_W'(MAX_AVERAGE_RST) * TOT_W'(WINDOW_LEN);
      ramp_end_q <= RAMP_END_RST;
    end else begin
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      mode_q  <= mode_d;
      duty_q  <= duty_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_AVERAGE: thresh_q <= TOT_W'(cfg_data_i[SAMPLE_W-1:0]) * TOT_W'(WINDOW_LEN);
          REG_RAMP_END:    ramp_end_q <= cfg_data_i[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_mode_q  <= mode_d;
      out_duty_q  <= duty_d;
      out_total_q <= TOTAL_W'({{TOTAL_W{1'b0}}, total_d});
      out_full_q  <= full_d;
      out_trip_q  <= tripped_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mode         = out_mode_q;
  assign out_o.duty         = out_duty_q;
  assign out_o.window_total = out_total_q;
  assign out_o.window_full  = out_full_q;
  assign out_o.tripped_now  = out_trip_q;
  assign out_o.pwm_running  = (out_mode_q == MODE_OFFLOADING);
  assign out_o.scr_fired    = (out_mode_q == MODE_OFF);

endmodule
